@@ rtl/mfhd_pkg.sv @@
`default_nettype none

package mfhd_pkg;

  localparam int LENGTH_FIELD_BYTES = 4;
  localparam int LEN_W              = 28;
  localparam int GROUP_BITS         = 7;
  localparam int BUF_W              = 16;
  localparam int CNT_W              = 3;
  localparam int IN_TDATA_W         = 8;
  localparam int OUT_TDATA_W        = 48;
  localparam logic [3:0] FIRST_NO_BODY_CHECK = 4'd12;
  localparam logic [BUF_W-1:0] BUFFER_SIZE_RESET = 16'd1024;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LONG  = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_MALFORMED = 2'd3
  } status_t;

  // bytes taken by the minimal encoding of a remaining length
  function automatic logic [2:0] min_len_bytes(input logic [LEN_W-1:0] len);
    logic [2:0] n;
    if (len < 28'd128) begin
      n = 3'd1;
    end else if (len < 28'd16384) begin
      n = 3'd2;
    end else if (len < 28'd2097152) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mqtt_fixed_header_deframer_unit.sv @@
// MQTT fixed-header deframer.
// Input stream s_axis carries the raw packet byte stream, one byte per request.
// Output stream m_axis carries one request per body byte; the last request of
// a packet has tlast set and carries type, flags, remaining length and status.
// Header and length bytes give no output request. A packet with an empty body,
// an oversize packet (body skipped) or a malformed length field gives a single
// tlast request with tuser (byte valid) low.
// cfg_wen/cfg_wdata set the buffer size (whole packet bytes); write it only
// while the block is idle.
// Each accepted byte is registered in the input register, then any result it
// gives in the output register. Throughput: one byte per cycle; the two
// registers form a two-stage pipeline, and the input side keeps taking
// bytes while the output is drained every cycle.
// When the receiver stalls, the output register holds, the input register
// fills and s_axis_tready drops until the output request is taken.
// Reset (rst, synchronous): waits for a header byte, both stages empty,
// buffer size 1024.
`default_nettype none

module mqtt_fixed_header_deframer_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [mfhd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [7:0] data_byte
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [7:0] body_byte, [11:8] packet_type, [15:12] header_flags,
  // [43:16] decoded_len, [45:44] status, [47:46] zero
  output logic [mfhd_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  output logic                                    m_axis_tlast,   // packet_end
  output logic                                    m_axis_tuser,   // byte_valid
  input  wire logic                               cfg_wen,
  input  wire logic [mfhd_pkg::BUF_W-1:0]         cfg_wdata
);
  import mfhd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  logic [BUF_W-1:0] buffer_size;

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             advance;

  phase_t           phase, phase_next;
  logic [7:0]       header_store, header_store_next;
  logic [LEN_W-1:0] length_accum, length_accum_next;
  logic [CNT_W-1:0] length_byte_count, length_byte_count_next;
  logic [LEN_W-1:0] body_left, body_left_next;
  logic             discarding, discarding_next;

  logic             res_fire;
  logic [7:0]       res_byte;
  logic             res_bv;
  logic             res_end;
  status_t          res_status;

  logic [LEN_W-1:0] acc_add;
  logic [LEN_W:0]   total;
  logic             too_long;
  logic [LEN_W-1:0] left_dec;

  logic [7:0]       out_byte;
  logic [3:0]       out_type;
  logic [3:0]       out_flags;
  logic [LEN_W-1:0] out_len;
  status_t          out_status;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  assign acc_add  = length_accum
                  + (LEN_W'(in_byte[GROUP_BITS-1:0]) << (GROUP_BITS * length_byte_count));
  assign total    = {1'b0, acc_add} + (LEN_W+1)'(1) + (LEN_W+1)'(min_len_bytes(acc_add));
  assign too_long = total > (LEN_W+1)'(buffer_size);
  assign left_dec = (body_left != '0) ? body_left - LEN_W'(1) : body_left;

  always_comb begin
    phase_next             = phase;
    header_store_next      = header_store;
    length_accum_next      = length_accum;
    length_byte_count_next = length_byte_count;
    body_left_next         = body_left;
    discarding_next        = discarding;
    res_fire               = 1'b0;
    res_byte               = '0;
    res_bv                 = 1'b0;
    res_end                = 1'b0;
    res_status             = ST_OK;
    case (phase)
      PH_HEADER: begin
        header_store_next      = in_byte;
        length_accum_next      = '0;
        length_byte_count_next = '0;
        body_left_next         = '0;
        discarding_next        = 1'b0;
        phase_next             = PH_LENGTH;
      end
      PH_LENGTH: begin
        if (length_byte_count >= CNT_W'(LENGTH_FIELD_BYTES)) begin
          res_fire               = 1'b1;
          res_end                = 1'b1;
          res_status             = ST_MALFORMED;
          phase_next             = PH_HEADER;
          body_left_next         = '0;
          discarding_next        = 1'b0;
          length_byte_count_next = '0;
        end else begin
          length_accum_next      = acc_add;
          length_byte_count_next = length_byte_count + CNT_W'(1);
          if (!in_byte[7]) begin
            if (acc_add == '0) begin
              res_fire = 1'b1;
              res_end  = 1'b1;
              if (too_long) begin
                res_status = ST_TOO_LONG;
              end else if (header_store[7:4] < FIRST_NO_BODY_CHECK) begin
                res_status = ST_EMPTY;
              end
              phase_next             = PH_HEADER;
              body_left_next         = '0;
              discarding_next        = 1'b0;
              length_byte_count_next = '0;
            end else begin
              discarding_next = too_long;
              body_left_next  = acc_add;
              phase_next      = PH_BODY;
            end
          end
        end
      end
      PH_BODY: begin
        body_left_next = left_dec;
        if (left_dec == '0) begin
          res_fire = 1'b1;
          res_end  = 1'b1;
          if (discarding) begin
            res_status = ST_TOO_LONG;
          end else begin
            res_byte = in_byte;
            res_bv   = 1'b1;
          end
          phase_next             = PH_HEADER;
          body_left_next         = '0;
          discarding_next        = 1'b0;
          length_byte_count_next = '0;
        end else if (!discarding) begin
          res_fire = 1'b1;
          res_byte = in_byte;
          res_bv   = 1'b1;
        end
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size       <= BUFFER_SIZE_RESET;
      in_valid          <= 1'b0;
      m_axis_tvalid     <= 1'b0;
      phase             <= PH_HEADER;
      header_store      <= '0;
      length_accum      <= '0;
      length_byte_count <= '0;
      body_left         <= '0;
      discarding        <= 1'b0;
    end else begin
      if (cfg_wen) begin
        buffer_size <= cfg_wdata;
      end
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        m_axis_tvalid     <= res_fire;
        phase             <= phase_next;
        header_store      <= header_store_next;
        length_accum      <= length_accum_next;
        length_byte_count <= length_byte_count_next;
        body_left         <= body_left_next;
        discarding        <= discarding_next;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
    if (advance && res_fire) begin
      out_byte     <= res_byte;
      m_axis_tuser <= res_bv;
      m_axis_tlast <= res_end;
      out_type     <= res_end ? header_store[7:4] : 4'd0;
      out_flags    <= res_end ? header_store[3:0] : 4'd0;
      out_len      <= res_end ? length_accum_next : '0;
      out_status   <= res_end ? res_status : ST_OK;
    end
  end

  assign m_axis_tdata = {2'b00, out_status, out_len, out_flags, out_type, out_byte};

`ifndef NO_ASSERTIONS
  a_mid_carries_byte: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> m_axis_tuser)
    else $error("non-final result without a body byte");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (out_status == ST_OK))
    else $error("status set on a non-final result");

  a_body_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (body_left != '0))
    else $error("body phase with nothing left to count");

  a_no_output_from_header: assert property (@(posedge clk) disable iff (rst)
    (advance && phase == PH_HEADER) |=> !m_axis_tvalid)
    else $error("header byte produced a result");
`endif

endmodule

`default_nettype wire
